// ===== rtl/md5de_pkg.sv =====
// ----------------------------------------------------------------------------
// md5de_pkg
// Types, constants and round tables shared by the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5de_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned RowCount   = 16;
   localparam int unsigned RoundCount = 64;

   localparam logic [31:0] IV_A     = 32'h67452301;
   localparam logic [31:0] IV_B     = 32'hefcdab89;
   localparam logic [31:0] IV_C     = 32'h98badcfe;
   localparam logic [31:0] IV_D     = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [3:0]  LEN_LO_ROW = 4'd14;
   localparam logic [3:0]  LEN_HI_ROW = 4'd15;
   localparam logic [4:0]  LEN_FIRST_ROW = 5'd15;

   typedef logic [3:0][31:0] chain_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic init;
   } round_ctrl_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] idx);
      logic [4:0] s;
      unique case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // block row used by round idx
   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [3:0] i4;
      logic [3:0] g;
      i4 = idx[3:0];
      unique case (idx[5:4])
         2'd0: g = i4;
         2'd1: g = 4'((i4 << 2) + i4 + 4'd1);
         2'd2: g = 4'((i4 << 1) + i4 + 4'd5);
         2'd3: g = 4'((i4 << 3) - i4);
         default: g = i4;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/md5de_msg_buffer.sv =====
// ----------------------------------------------------------------------------
// md5de_msg_buffer
// Sixteen-row block buffer; rows past the fill count read as zero, and the
// length rows read the bit count on a length block.
// ----------------------------------------------------------------------------
module md5de_msg_buffer
   import md5de_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_row,
   input  logic [31:0] wr_word,
   input  logic [3:0]  rd_row,
   input  logic [4:0]  row_count,
   input  logic        len_en,
   input  logic [63:0] bit_length,
   output logic [31:0] rd_word
);

   logic [31:0] row_ff [RowCount];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_ff[wr_row] <= wr_word;
      end
   end

   always_comb begin
      priority if ({1'b0, rd_row} < row_count) begin
         rd_word = row_ff[rd_row];
      end else if (len_en && rd_row == LEN_LO_ROW) begin
         rd_word = bit_length[31:0];
      end else if (len_en && rd_row == LEN_HI_ROW) begin
         rd_word = bit_length[63:32];
      end else begin
         rd_word = '0;
      end
   end

endmodule

// ===== rtl/md5de_round_unit.sv =====
// ----------------------------------------------------------------------------
// md5de_round_unit
// Chaining words, working registers a..d and the one shared MD5 round.
// ----------------------------------------------------------------------------
module md5de_round_unit
   import md5de_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctrl_type ctrl,
   input  logic [5:0]     round_idx,
   input  logic [5:0]     next_idx,
   input  logic [31:0]    msg_word,
   output chain_type      chain
);

   chain_type   chain_ff;
   chain_type   chain_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] km_ff;
   logic [31:0] f_val;
   logic [31:0] sum_val;
   logic [63:0] rot_wide;
   logic [31:0] b_in;

   always_comb begin
      unique case (round_idx[5:4])
         2'd0: f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = '0;
      endcase
      sum_val  = a_ff + f_val + km_ff;
      rot_wide = {sum_val, sum_val} << rot_amount(round_idx);
      b_in     = b_ff + rot_wide[63:32];
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.init) begin
         chain_in = {IV_D, IV_C, IV_B, IV_A};
      end else if (ctrl.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= {IV_D, IV_C, IV_B, IV_A};
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (ctrl.step) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= b_in;
      end
      if (ctrl.load || ctrl.step) begin
         km_ff <= round_const(next_idx) + msg_word;
      end
   end

   assign chain = chain_ff;

endmodule

// ===== rtl/md5_digest_engine.sv =====
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 hash over a stream of 32-bit message words, four digest words out.
// ----------------------------------------------------------------------------
// A non-last word is written into the block buffer; the sixteenth word of a
// block starts a compression (a load step, 64 rounds on the single shared
// round unit, a chaining add), during which req_tready is low. A last word
// that fills the block first runs that compression. The last word then adds
// padding, then one compression, or two with a pass through the check state
// between them when the 0x80 marker lands in byte 56 or later, then four
// digest words are offered, one per cycle while rsp_tready is high. The chain
// is then reset for the next message.
module md5_digest_engine
   import md5de_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [33:32] word_index, rest zero
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_CHECK, S_PREP, S_ROUND, S_FOLD, S_OUT
   } state_type;

   state_type      state_ff, after_ff;
   logic [4:0]     rows_ff;
   logic [5:0]     rnd_ff;
   logic [63:0]    bitlen_ff;
   logic           len_ff;
   logic [1:0]     widx_ff;

   logic [31:0]    data_word;
   logic [2:0]     byte_count;
   logic [2:0]     count_sat;
   logic [31:0]    tail_word;
   logic           req_fire;
   logic           rsp_fire;
   logic           wr_en;
   logic [31:0]    wr_word;
   logic [5:0]     next_idx;
   logic [31:0]    msg_word;
   round_ctrl_type ctrl;
   chain_type      chain;

   assign data_word  = req_tdata[31:0];
   assign byte_count = req_tdata[34:32];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {6'b0, widx_ff, chain[widx_ff]};
   assign rsp_tlast  = (widx_ff == 2'd3);

   always_comb begin
      count_sat = (!req_tlast || byte_count > 3'd4) ? 3'd4 : byte_count;
      unique case (count_sat[1:0])
         2'd0: tail_word = {24'b0, PAD_BYTE};
         2'd1: tail_word = {16'b0, PAD_BYTE, data_word[7:0]};
         2'd2: tail_word = {8'b0, PAD_BYTE, data_word[15:0]};
         2'd3: tail_word = {PAD_BYTE, data_word[23:0]};
         default: tail_word = data_word;
      endcase
      if (count_sat == 3'd4) begin
         tail_word = data_word;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_word = data_word;
      if (req_fire) begin
         wr_en   = 1'b1;
         wr_word = tail_word;
      end else if (state_ff == S_PAD) begin
         wr_en   = 1'b1;
         wr_word = {24'b0, PAD_BYTE};
      end
   end

   assign next_idx = (state_ff == S_PREP) ? 6'd0 : rnd_ff + 6'd1;

   always_comb begin
      ctrl.load = (state_ff == S_PREP);
      ctrl.step = (state_ff == S_ROUND);
      ctrl.fold = (state_ff == S_FOLD);
      ctrl.init = rsp_fire && (widx_ff == 2'd3);
   end

   md5de_msg_buffer u_buffer (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_row     (rows_ff[3:0]),
      .wr_word    (wr_word),
      .rd_row     (msg_index(next_idx)),
      .row_count  (rows_ff),
      .len_en     (len_ff),
      .bit_length (bitlen_ff),
      .rd_word    (msg_word)
   );

   md5de_round_unit u_round (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .round_idx (rnd_ff),
      .next_idx  (next_idx),
      .msg_word  (msg_word),
      .chain     (chain)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         after_ff  <= S_IDLE;
         rows_ff   <= '0;
         rnd_ff    <= '0;
         bitlen_ff <= '0;
         len_ff    <= 1'b0;
         widx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rows_ff   <= rows_ff + 5'd1;
                  bitlen_ff <= bitlen_ff + {58'b0, count_sat, 3'b0};
                  len_ff    <= 1'b0;
                  if (!req_tlast) begin
                     if (rows_ff == 5'd15) begin
                        after_ff <= S_IDLE;
                        state_ff <= S_PREP;
                     end
                  end else if (count_sat == 3'd4) begin
                     if (rows_ff == 5'd15) begin
                        after_ff <= S_PAD;
                        state_ff <= S_PREP;
                     end else begin
                        state_ff <= S_PAD;
                     end
                  end else begin
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_PAD: begin
               rows_ff  <= rows_ff + 5'd1;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (rows_ff >= LEN_FIRST_ROW) begin
                  len_ff   <= 1'b0;
                  after_ff <= S_CHECK;
               end else begin
                  len_ff   <= 1'b1;
                  after_ff <= S_OUT;
               end
               state_ff <= S_PREP;
            end
            S_PREP: begin
               rnd_ff   <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'(RoundCount - 1)) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               rows_ff  <= '0;
               len_ff   <= 1'b0;
               widx_ff  <= '0;
               state_ff <= after_ff;
            end
            S_OUT: begin
               if (rsp_fire) begin
                  widx_ff <= widx_ff + 2'd1;
                  if (widx_ff == 2'd3) begin
                     bitlen_ff <= '0;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
